// ----- hdl/panv_pkg.sv -----
// ----------------------------------------------------------------------------
// panv_pkg
// Shared types and constants of the path arc-length / nearest-vertex block.
// ----------------------------------------------------------------------------
`default_nettype none
package panv_pkg;
	localparam int MAX_VERTICES_DEF = 256;
	localparam int FRAC_BITS_DEF    = 8;
	localparam logic [17:0] SCALE_ONE = 18'd65536;
	localparam logic [17:0] SCALE_MAX = 18'd262143;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD_RD,
		ST_LOAD_SQ,
		ST_LOAD_SQRT,
		ST_LOAD_WR,
		ST_CLOSE_RD,
		ST_CLOSE_SQ,
		ST_CLOSE_SQRT,
		ST_DIV,
		ST_EMIT,
		ST_QRY_RD,
		ST_QRY_CMP,
		ST_QRY_POS_RD,
		ST_QRY_MUL,
		ST_QRY_EMIT
	} panv_state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;       // latch request fields
		logic new_path;      // clear path state before storing
		logic rd_prev;       // read vertex count-1
		logic rd_last;       // read vertex count-1 for closing chord
		logic rd_first;      // read vertex 0 / first scan entry
		logic rd_next;       // read next scan entry
		logic rd_pos;        // read position of best
		logic sq;            // compute squared distance
		logic sqrt_start;
		logic add_len;
		logic wr_vertex;
		logic div_start;
		logic cmp;
		logic mul;
		logic emit_len;
		logic emit_qry;
		logic emit_empty;
		logic set_closed;
	} panv_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_query;
		logic last_pt;
		logic closed;
		logic cnt_zero;
		logic cnt_full;
		logic have_prev;
		logic sqrt_done;
		logic div_done;
		logic scan_last;
	} panv_stat_t;
endpackage
`default_nettype wire

// ----- hdl/panv_sqrt.sv -----
// ----------------------------------------------------------------------------
// panv_sqrt
// Bit-serial square root rounded to nearest, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module panv_sqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [49:0] radicand,
	output logic             done,
	output logic [25:0]      root
);
	logic [51:0] rem_q;
	logic [25:0] r_q;
	logic [49:0] s_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic [51:0] trial;
	logic [51:0] rem_sh;

	// restoring step: bring down two bits, try 4r+1
	assign rem_sh = {rem_q[49:0], s_q[49:48]};
	assign trial  = rem_sh - {24'd0, r_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 5'd24;
			end else if (run_q) begin
				if (cnt_q == 5'd0) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			r_q   <= '0;
			s_q   <= radicand;
		end else if (run_q) begin
			s_q <= {s_q[47:0], 2'b00};
			if (!trial[51]) begin
				rem_q <= trial;
				r_q   <= {r_q[24:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				r_q   <= {r_q[24:0], 1'b0};
			end
		end
	end

	// remainder above root means round up
	assign root = r_q + 26'(rem_q > {26'd0, r_q});
endmodule
`default_nettype wire

// ----- hdl/panv_div.sv -----
// ----------------------------------------------------------------------------
// panv_div
// Restoring divider for the length scale, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module panv_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [63:0] quotient
);
	logic [32:0] rem_q;
	logic [63:0] q_q;
	logic [6:0]  cnt_q;
	logic        run_q;
	logic [32:0] sh;
	logic [33:0] diff;

	assign sh   = {rem_q[31:0], q_q[63]};
	assign diff = {1'b0, sh} - {2'b00, divisor};
	assign quotient = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 7'd63;
			end else if (run_q) begin
				if (cnt_q == 7'd0) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q   <= dividend;
		end else if (run_q) begin
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				q_q   <= {q_q[62:0], 1'b1};
			end else begin
				rem_q <= sh;
				q_q   <= {q_q[62:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ----- hdl/panv_datapath.sv -----
// ----------------------------------------------------------------------------
// panv_datapath
// Vertex memories, chord length accumulation, scale and nearest-vertex scan.
// ----------------------------------------------------------------------------
`default_nettype none
module panv_datapath import panv_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire panv_cmd_t    cmd,
	output panv_stat_t        stat,
	input  wire logic         mode,
	input  wire logic signed [23:0] coord_x,
	input  wire logic signed [23:0] coord_y,
	input  wire logic         last_point,
	output logic [7:0]        nearest_index,
	output logic [31:0]       path_position,
	output logic [23:0]       total_length,
	output logic              no_points,
	output logic              done
);
	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	logic [23:0] mem_x [MAX_VERTICES];
	logic [23:0] mem_y [MAX_VERTICES];
	logic [31:0] mem_p [MAX_VERTICES];

	logic [23:0] rd_x_q, rd_y_q;
	logic [23:0] ax_q, ay_q;
	logic [31:0] pos_q;
	logic        mode_q, last_q, closed_q;
	logic [CW-1:0] cnt_q;
	logic [31:0] run_q;
	logic [17:0] scale_q;
	logic [AW-1:0] raddr;
	logic [AW-1:0] scan_q, best_q;
	logic [48:0] best_d_q;
	logic        best_vld_q;
	logic [49:0] dsq_q;
	logic [24:0] dx, dy;
	logic [24:0] ux, uy;
	logic [48:0] d_now;
	logic [25:0] root;
	logic        sqrt_done, div_done;
	logic [63:0] quot;
	logic [31:0] tlen;
	logic [63:0] dividend;
	logic [49:0] prod;
	logic [32:0] sum;
	logic [AW-1:0] cnt_m1;

	assign cnt_m1 = AW'(cnt_q - CW'(1));

	// memory read address select
	always_comb begin
		raddr = '0;
		if (cmd.rd_prev || cmd.rd_last) raddr = cnt_m1;
		else if (cmd.rd_next) raddr = AW'(scan_q + AW'(1));
		else if (cmd.rd_pos) raddr = best_q;
	end

	// vertex memories
	always_ff @(posedge clk) begin
		if (cmd.wr_vertex) begin
			mem_x[cnt_q[AW-1:0]] <= ax_q;
			mem_y[cnt_q[AW-1:0]] <= ay_q;
			mem_p[cnt_q[AW-1:0]] <= run_q;
		end
		rd_x_q <= mem_x[raddr];
		rd_y_q <= mem_y[raddr];
		pos_q  <= mem_p[raddr];
	end

	// closing chord uses vertex 0 as the second point
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ax_q   <= coord_x;
			ay_q   <= coord_y;
			mode_q <= mode;
			last_q <= last_point;
		end else if (cmd.rd_first && !mode_q) begin
			ax_q <= mem_x[0];
			ay_q <= mem_y[0];
		end
	end

	// squared distance of read entry and held point
	assign dx = {ax_q[23], ax_q} - {rd_x_q[23], rd_x_q};
	assign dy = {ay_q[23], ay_q} - {rd_y_q[23], rd_y_q};
	assign ux = dx[24] ? -dx : dx;
	assign uy = dy[24] ? -dy : dy;
	always_ff @(posedge clk) begin
		if (cmd.sq || cmd.cmp) dsq_q <= 50'(ux * ux) + 50'(uy * uy);
	end
	assign d_now = dsq_q[48:0];

	panv_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(cmd.sqrt_start),
		.radicand(dsq_q), .done(sqrt_done), .root(root)
	);

	assign tlen = 32'((33'(run_q) + 33'((1 << FRAC_BITS) >> 1)) >> FRAC_BITS);
	assign dividend = ({32'd0, tlen} << (16 + FRAC_BITS)) + 64'(run_q >> 1);

	panv_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(dividend), .divisor(run_q), .done(div_done), .quotient(quot)
	);

	assign sum = 33'(run_q) + 33'(root);

	// path control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			run_q    <= '0;
			scale_q  <= SCALE_ONE;
			closed_q <= 1'b0;
		end else begin
			if (cmd.new_path) begin
				cnt_q    <= '0;
				run_q    <= '0;
				scale_q  <= SCALE_ONE;
				closed_q <= 1'b0;
			end
			if (cmd.add_len) run_q <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			if (cmd.wr_vertex) cnt_q <= cnt_q + CW'(1);
			if (div_done && run_q != 32'd0)
				scale_q <= (quot > 64'(SCALE_MAX)) ? SCALE_MAX : quot[17:0];
			if (cmd.set_closed) closed_q <= 1'b1;
		end
	end

	// nearest scan: compare the squared distance of each entry
	always_ff @(posedge clk) begin
		if (cmd.rd_first) begin
			scan_q     <= '0;
			best_q     <= '0;
			best_vld_q <= 1'b0;
		end else if (cmd.rd_next) begin
			scan_q <= AW'(scan_q + AW'(1));
		end
		if (cmd.cmp && (!best_vld_q || d_now < best_d_q)) begin
			best_d_q   <= d_now;
			best_q     <= scan_q;
			best_vld_q <= 1'b1;
		end
	end

	// scaled position
	always_ff @(posedge clk) begin
		if (cmd.mul) prod <= 50'(pos_q * scale_q);
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.emit_len | cmd.emit_qry | cmd.emit_empty;
		end
	end

	always_ff @(posedge clk) begin
		nearest_index <= '0;
		path_position <= '0;
		total_length  <= '0;
		no_points     <= 1'b0;
		if (cmd.emit_len)
			total_length <= (tlen > 32'hFF_FFFF) ? 24'hFF_FFFF : tlen[23:0];
		if (cmd.emit_empty) no_points <= 1'b1;
		if (cmd.emit_qry) begin
			nearest_index <= 8'(best_q);
			path_position <= ((prod + 50'd32768) >> 16) > 50'hFFFF_FFFF ? 32'hFFFF_FFFF
				: 32'((prod + 50'd32768) >> 16);
		end
	end

	assign stat.is_query  = mode_q;
	assign stat.last_pt   = last_q;
	assign stat.closed    = closed_q;
	assign stat.cnt_zero  = (cnt_q == '0);
	assign stat.cnt_full  = (cnt_q == CW'(MAX_VERTICES));
	assign stat.have_prev = (cnt_q != '0);
	assign stat.sqrt_done = sqrt_done;
	assign stat.div_done  = div_done;
	assign stat.scan_last = (CW'(scan_q) == CW'(cnt_q - CW'(1)));
endmodule
`default_nettype wire

// ----- hdl/panv_ctrl.sv -----
// ----------------------------------------------------------------------------
// panv_ctrl
// Sequencer for load, close and query requests.
// ----------------------------------------------------------------------------
`default_nettype none
module panv_ctrl import panv_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire panv_stat_t stat,
	output panv_cmd_t       cmd
);
	panv_state_t state_q, state_d;
	logic newp_q, newp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			newp_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			newp_q  <= newp_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		newp_d  = newp_q;
		cmd     = '0;
		busy    = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d = ST_LOAD_RD;
				end
			end
			ST_LOAD_RD: begin
				if (stat.is_query) begin
					if (stat.cnt_zero) begin
						cmd.emit_empty = 1'b1;
						state_d = ST_QRY_EMIT;
					end else begin
						cmd.rd_first = 1'b1;
						state_d = ST_QRY_RD;
					end
				end else if (stat.closed) begin
					cmd.new_path = 1'b1;
				end else if (stat.cnt_full) begin
					state_d = ST_LOAD_WR;
				end else if (stat.have_prev) begin
					cmd.rd_prev = 1'b1;
					state_d = ST_LOAD_SQ;
				end else begin
					state_d = ST_LOAD_WR;
				end
			end
			ST_LOAD_SQ: begin
				cmd.sq = 1'b1;
				newp_d = 1'b1;
				state_d = ST_LOAD_SQRT;
			end
			ST_LOAD_SQRT: begin
				if (newp_q) begin
					cmd.sqrt_start = 1'b1;
					newp_d = 1'b0;
				end else if (stat.sqrt_done) begin
					cmd.add_len = 1'b1;
					state_d = ST_LOAD_WR;
				end
			end
			ST_LOAD_WR: begin
				cmd.wr_vertex = !stat.cnt_full;
				if (!stat.last_pt) state_d = ST_QRY_EMIT;
				else state_d = ST_CLOSE_RD;
			end
			ST_CLOSE_RD: begin
				if (stat.cnt_zero) begin
					state_d = ST_DIV;
					newp_d = 1'b1;
				end else begin
					cmd.rd_last  = 1'b1;
					cmd.rd_first = 1'b1;
					state_d = ST_CLOSE_SQ;
				end
			end
			ST_CLOSE_SQ: begin
				cmd.sq = 1'b1;
				newp_d = 1'b1;
				state_d = ST_CLOSE_SQRT;
			end
			ST_CLOSE_SQRT: begin
				if (newp_q) begin
					cmd.sqrt_start = 1'b1;
					newp_d = 1'b0;
				end else if (stat.sqrt_done) begin
					cmd.add_len = 1'b1;
					newp_d = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (newp_q) begin
					cmd.div_start = 1'b1;
					newp_d = 1'b0;
				end else if (stat.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit_len   = 1'b1;
				cmd.set_closed = 1'b1;
				state_d = ST_QRY_EMIT;
			end
			ST_QRY_RD: begin
				state_d = ST_QRY_CMP;
			end
			ST_QRY_CMP: begin
				cmd.sq = 1'b1;
				state_d = ST_QRY_POS_RD;
			end
			ST_QRY_POS_RD: begin
				cmd.cmp = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_QRY_MUL;
				end else begin
					cmd.rd_next = 1'b1;
					state_d = ST_QRY_CMP;
				end
			end
			ST_QRY_MUL: begin
				if (!newp_q) begin
					cmd.rd_pos = 1'b1;
					newp_d = 1'b1;
				end else begin
					cmd.mul = 1'b1;
					newp_d = 1'b0;
					state_d = ST_QRY_EMIT;
				end
			end
			ST_QRY_EMIT: begin
				if (stat.is_query && !stat.cnt_zero && !newp_q) begin
					cmd.emit_qry = 1'b1;
					newp_d = 1'b1;
				end else begin
					newp_d = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ----- hdl/path_arclength_nearest_vertex.sv -----
// ----------------------------------------------------------------------------
// path_arclength_nearest_vertex
// Closed polygon arc-length parameterization with nearest-vertex query.
// ----------------------------------------------------------------------------
// Usage: drive mode, coord_x, coord_y and last_point and raise start while
// busy is low; the request is taken at that edge. Load requests append a
// vertex while the store has room; one that carries last_point closes the
// path and returns the rounded perimeter on total_length. Query requests
// return nearest_index and path_position, or no_points for an empty store.
// A result is valid for the one cycle that done is high; the receiver
// cannot stall it. A load that follows a stored vertex runs a 25-step
// bit-serial square root; a closing load adds the closing root and a
// 64-step divider; a query scans the stored vertices through the single
// read port of the vertex memory. One request at a time.
// Reset clears the vertex count, path length and scale; the vertex
// memories need no clearing since only written entries are read.
// ----------------------------------------------------------------------------
`default_nettype none
module path_arclength_nearest_vertex import panv_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        mode,
	input  wire logic signed [23:0] coord_x,
	input  wire logic signed [23:0] coord_y,
	input  wire logic        last_point,
	output logic             done,
	output logic [7:0]       nearest_index,
	output logic [31:0]      path_position,
	output logic [23:0]      total_length,
	output logic             no_points
);
	panv_cmd_t  cmd;
	panv_stat_t stat;

	panv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.stat(stat), .cmd(cmd)
	);

	panv_datapath #(.MAX_VERTICES(MAX_VERTICES), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.mode(mode), .coord_x(coord_x), .coord_y(coord_y), .last_point(last_point),
		.nearest_index(nearest_index), .path_position(path_position),
		.total_length(total_length), .no_points(no_points), .done(done)
	);
endmodule
`default_nettype wire

// ----- tb/path_arclength_nearest_vertex_test.sv -----
// ----------------------------------------------------------------------------
// path_arclength_nearest_vertex_test
// Self-checking bench for the path arc-length / nearest-vertex block. A
// behavioral predictor keeps its own vertex store, chord sum and scale,
// computes the expected perimeter and nearest-vertex results for each
// request, and a monitor compares every done strobe against them.
// ----------------------------------------------------------------------------
`default_nettype none
module path_arclength_nearest_vertex_test;
	import panv_pkg::*;

	localparam int NV = MAX_VERTICES_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef enum logic {OP_LOAD = 1'b0, OP_QUERY = 1'b1} op_t;

	typedef struct packed {
		logic [7:0]  idx;
		logic [31:0] pos;
		logic [23:0] tlen;
		logic        empty;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic mode = 1'b0;
	logic signed [23:0] coord_x = '0;
	logic signed [23:0] coord_y = '0;
	logic last_point = 1'b0;
	logic busy, done, no_points;
	logic [7:0] nearest_index;
	logic [31:0] path_position;
	logic [23:0] total_length;

	path_arclength_nearest_vertex dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.coord_x(coord_x), .coord_y(coord_y), .last_point(last_point),
		.done(done), .nearest_index(nearest_index), .path_position(path_position),
		.total_length(total_length), .no_points(no_points)
	);

	always #6 clk = ~clk;

	// predictor state
	logic signed [23:0] px [NV];
	logic signed [23:0] py [NV];
	logic [31:0] praw [NV];
	int unsigned pcount;
	logic [31:0] plen;
	logic [17:0] pscale;
	bit pclosed;

	answer_t answers_due[$];
	int errors = 0;
	int results_seen = 0;
	int requests_sent = 0;
	longint cycles = 0;

	function automatic logic [63:0] dist2(logic signed [23:0] ax, logic signed [23:0] ay,
			logic signed [23:0] bx, logic signed [23:0] by);
		longint dx, dy;
		dx = longint'(bx) - longint'(ax);
		dy = longint'(by) - longint'(ay);
		return dx * dx + dy * dy;
	endfunction

	function automatic logic [63:0] root_nearest(logic [63:0] s);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s = s - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (s > r) r = r + 1;
		return r;
	endfunction

	function automatic void grow_length(logic [63:0] chord);
		logic [63:0] sum;
		sum = {32'd0, plen} + chord;
		plen = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	// advance the predictor by one request; returns 1 when a result is due
	function automatic bit predict_path(op_t op, logic signed [23:0] x,
			logic signed [23:0] y, logic lp, output answer_t a);
		logic [63:0] raw, tl, sc, bd, d, pos;
		int unsigned best;
		a = '0;
		if (op == OP_LOAD) begin
			if (pclosed) begin
				pcount = 0; plen = 0; pscale = SCALE_ONE; pclosed = 0;
			end
			if (pcount < NV) begin
				if (pcount > 0)
					grow_length(root_nearest(dist2(px[pcount-1], py[pcount-1], x, y)));
				px[pcount] = x; py[pcount] = y; praw[pcount] = plen;
				pcount++;
			end
			if (!lp) return 0;
			if (pcount > 0)
				grow_length(root_nearest(dist2(px[pcount-1], py[pcount-1], px[0], py[0])));
			raw = plen;
			tl = (raw + ((64'd1 << FB) >> 1)) >> FB;
			if (raw != 0) begin
				sc = ((tl << (16 + FB)) + (raw >> 1)) / raw;
				pscale = (sc > SCALE_MAX) ? SCALE_MAX : sc[17:0];
			end
			pclosed = 1;
			a.tlen = (tl > 64'hFF_FFFF) ? 24'hFF_FFFF : tl[23:0];
			return 1;
		end
		if (pcount == 0) begin
			a.empty = 1;
			return 1;
		end
		best = 0;
		bd = dist2(px[0], py[0], x, y);
		for (int i = 1; i < pcount; i++) begin
			d = dist2(px[i], py[i], x, y);
			if (d < bd) begin bd = d; best = i; end
		end
		pos = ({32'd0, praw[best]} * pscale + 64'd32768) >> 16;
		a.idx = best[7:0];
		a.pos = (pos > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pos[31:0];
		return 1;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
			results_seen);
		errors++;
	endtask

	// result monitor
	always @(posedge clk) begin
		answer_t w;
		cycles++;
		if (arst_n && done) begin
			results_seen++;
			if (answers_due.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				w = answers_due.pop_front();
				if (nearest_index !== w.idx) report_mismatch("nearest_index", nearest_index, w.idx);
				if (path_position !== w.pos) report_mismatch("path_position", path_position, w.pos);
				if (total_length !== w.tlen) report_mismatch("total_length", total_length, w.tlen);
				if (no_points !== w.empty) report_mismatch("no_points", no_points, w.empty);
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// sender burst/gap pattern
	int burst_left = 0;

	task automatic send_request(op_t op, logic signed [23:0] x, logic signed [23:0] y,
			logic lp);
		answer_t a;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			repeat (gap) @(negedge clk);
		end
		burst_left--;
		// start was lowered at the previous falling edge
		@(negedge clk);
		start <= 1'b1;
		mode <= op;
		coord_x <= x;
		coord_y <= y;
		last_point <= lp;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (predict_path(op, x, y, lp, a)) answers_due = {answers_due, a};
		requests_sent++;
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic drain_results();
		while (answers_due.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	function automatic logic signed [23:0] pick_coord(int spread);
		case (spread)
			0: return $urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000;
			1: return $signed(24'($urandom_range(0, 4095)) - 24'd2048);
			default: return $signed(24'($urandom));
		endcase
	endfunction

	task automatic test_extremes();
		send_request(OP_QUERY, 24'sd0, 24'sd0, 1'b0);            // empty store
		send_request(OP_LOAD, 24'sd5, 24'sd5, 1'b1);             // one-vertex path, zero perimeter
		send_request(OP_QUERY, 24'sd0, 24'sd0, 1'b0);
		send_request(OP_LOAD, -24'sh800000, -24'sh800000, 1'b0);
		send_request(OP_LOAD, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
		send_request(OP_QUERY, 24'sd1, 24'sd1, 1'b0);            // unclosed path
		send_request(OP_LOAD, 24'sh7FFFFF, -24'sh800000, 1'b1);
		send_request(OP_QUERY, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
		send_request(OP_QUERY, 24'sh7FFFFF, -24'sh800000, 1'b0);
		send_request(OP_LOAD, 24'sd0, 24'sd0, 1'b0);             // new path after close
		send_request(OP_LOAD, 24'sd1, 24'sd0, 1'b0);
		send_request(OP_LOAD, 24'sd0, 24'sd1, 1'b1);             // tiny perimeter, length and scale round to zero
		send_request(OP_QUERY, 24'sd1, 24'sd1, 1'b0);
		send_request(OP_QUERY, 24'sd0, 24'sd1, 1'b0);
		drain_results();
	endtask

	task automatic test_store_full();
		for (int i = 0; i < NV + 3; i++)
			send_request(OP_LOAD, pick_coord(1), pick_coord(1), 1'b0);
		send_request(OP_QUERY, pick_coord(1), pick_coord(1), 1'b0);
		send_request(OP_LOAD, pick_coord(1), pick_coord(1), 1'b1); // full store still closes
		for (int i = 0; i < 6; i++)
			send_request(OP_QUERY, pick_coord(1), pick_coord(1), 1'b0);
		drain_results();
	endtask

	task automatic test_random_paths(int budget);
		int n, spread;
		while (budget > 0) begin
			spread = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 2);
			n = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
			if ($urandom_range(0, 5) == 0)
				send_request(OP_QUERY, pick_coord(spread), pick_coord(spread), 1'b0);
			for (int i = 0; i < n; i++) begin
				send_request(OP_LOAD, pick_coord(spread), pick_coord(spread),
					i == n - 1 && $urandom_range(0, 7) != 0);
				if ($urandom_range(0, 7) == 0)
					send_request(OP_QUERY, pick_coord(spread), pick_coord(spread), 1'b0);
			end
			for (int q = $urandom_range(1, 5); q > 0; q--)
				send_request(OP_QUERY, pick_coord(spread), pick_coord(spread),
					1'($urandom));
			budget -= n + 3;
			if ($urandom_range(0, 15) == 0)
				while (answers_due.size() != 0) @(negedge clk); // sender holds off
		end
		drain_results();
	endtask

	initial begin
		pcount = 0; plen = 0; pscale = SCALE_ONE; pclosed = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_extremes();
		test_store_full();
		test_random_paths(700);
		$display("sent %0d requests, checked %0d results", requests_sent, results_seen);
		$display("covered empty, degenerate, saturating, full-store and random paths");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
`default_nettype wire
